// ----- src/i2cm_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
// No dependencies; used by i2cm_step, i2c_master_byte_engine_top and the testbench.
package i2cm_pkg;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  localparam logic [4:0] SEG_SHORT   = 5'd3;
  localparam logic [4:0] SEG_LONG    = 5'd19;
  localparam logic [4:0] PH_BITS_END = 5'd16;
  localparam logic [4:0] PH_ACK_LOW  = 5'd16;
  localparam logic [4:0] PH_ACK_HIGH = 5'd17;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
  localparam logic       REG_HALF_PERIOD   = 1'b0;

  typedef struct packed {
    logic       sda_in;
    logic       ack_to_send;
    logic [7:0] tx_byte;
    logic [1:0] mode;
    logic       cmd_valid;
  } cmd_t;

  typedef struct packed {
    logic       ack_seen;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       scl;
  } res_t;

  typedef struct packed {
    logic       active;
    mode_t      mode;
    logic [4:0] phase;
    logic [7:0] wait_count;
    logic [7:0] shift_reg;
    logic       scl_level;
    logic       sda_level;
    logic       ack_reg;
    logic [7:0] rx_hold;
    logic       ack_out;
  } state_t;

endpackage

// ----- src/i2cm_step.sv -----
// One tick of the I2C byte engine: next state and result from state and input.
// Depends on i2cm_pkg.
module i2cm_step (
  input  i2cm_pkg::state_t st,
  input  i2cm_pkg::cmd_t   cmd,
  input  logic [7:0]       half_period,
  output i2cm_pkg::state_t st_next,
  output i2cm_pkg::res_t   res
);

  logic             start;
  logic             act;
  i2cm_pkg::mode_t  md;
  logic [7:0]       hp;
  logic [7:0]       sh;
  logic [4:0]       ph;
  logic [7:0]       wc;
  logic [8:0]       wc_inc;
  logic [4:0]       ph_inc;
  logic [4:0]       seg_count;
  logic             scl_l;
  logic             sda_l;
  logic             ack_l;
  logic [7:0]       rx_l;
  logic             done;
  logic [2:0]       bit_sel;

  always_comb begin
    hp      = (half_period == 8'd0) ? 8'd1 : half_period;
    start   = !st.active && cmd.cmd_valid;
    act     = st.active || start;
    md      = start ? i2cm_pkg::mode_t'(cmd.mode) : st.mode;
    sh      = st.shift_reg;
    if (start) begin
      sh = (md == i2cm_pkg::MODE_WRITE) ? cmd.tx_byte : 8'd0;
    end
    ph      = start ? 5'd0 : st.phase;
    wc      = start ? 8'd0 : st.wait_count;
    bit_sel = 3'd7 - ph[3:1];
    scl_l   = st.scl_level;
    sda_l   = st.sda_level;
    ack_l   = st.ack_reg;
    rx_l    = st.rx_hold;
    done    = 1'b0;
    wc_inc  = {1'b0, wc} + 9'd1;
    ph_inc  = ph + 5'd1;
    seg_count = (md == i2cm_pkg::MODE_START || md == i2cm_pkg::MODE_STOP) ?
                i2cm_pkg::SEG_SHORT : i2cm_pkg::SEG_LONG;

    st_next         = st;
    st_next.ack_out = start ? cmd.ack_to_send : st.ack_out;
    st_next.mode    = md;

    if (act) begin
      if (wc == 8'd0) begin
        unique case (md)
          i2cm_pkg::MODE_START: begin
            if (ph == 5'd0) begin
              scl_l = 1'b0;
            end else if (ph == 5'd1) begin
              scl_l = 1'b1;
              sda_l = 1'b1;
            end else begin
              sda_l = 1'b0;
            end
          end
          i2cm_pkg::MODE_STOP: begin
            if (ph == 5'd0) begin
              scl_l = 1'b0;
            end else if (ph == 5'd1) begin
              scl_l = 1'b1;
              sda_l = 1'b0;
            end else begin
              sda_l = 1'b1;
            end
          end
          default: begin
            if (ph < i2cm_pkg::PH_BITS_END) begin
              if (!ph[0]) begin
                scl_l = 1'b0;
                sda_l = (md == i2cm_pkg::MODE_WRITE) ? sh[bit_sel] : 1'b1;
              end else begin
                scl_l = 1'b1;
              end
            end else if (ph == i2cm_pkg::PH_ACK_LOW) begin
              scl_l = 1'b0;
              sda_l = (md == i2cm_pkg::MODE_WRITE) ? 1'b1 : st_next.ack_out;
            end else if (ph == i2cm_pkg::PH_ACK_HIGH) begin
              scl_l = 1'b1;
            end else begin
              scl_l = 1'b0;
            end
          end
        endcase
      end

      if (md == i2cm_pkg::MODE_READ && ph < i2cm_pkg::PH_BITS_END && ph[0] && wc == 8'd0) begin
        sh = {sh[6:0], cmd.sda_in};
      end
      if (md == i2cm_pkg::MODE_WRITE && ph == i2cm_pkg::PH_ACK_HIGH && wc == hp - 8'd1) begin
        ack_l = cmd.sda_in;
      end

      st_next.active     = 1'b1;
      st_next.phase      = ph;
      st_next.wait_count = wc_inc[7:0];
      if (wc_inc >= {1'b0, hp}) begin
        st_next.wait_count = 8'd0;
        st_next.phase      = ph_inc;
        if (ph_inc >= seg_count) begin
          done = 1'b1;
          if (md == i2cm_pkg::MODE_READ) begin
            rx_l = sh;
          end
          st_next.active = 1'b0;
          st_next.phase  = 5'd0;
        end
      end
    end

    st_next.shift_reg = sh;
    st_next.scl_level = scl_l;
    st_next.sda_level = sda_l;
    st_next.ack_reg   = ack_l;
    st_next.rx_hold   = rx_l;

    res.scl       = scl_l;
    res.sda_drive = sda_l;
    res.busy_res  = act;
    res.done_res  = done;
    res.rx_byte   = rx_l;
    res.ack_seen  = ack_l;
  end

endmodule

// ----- src/i2c_master_byte_engine_top.sv -----
// Top level of the tick-driven I2C master byte engine: stream ports, APB register, state.
// Depends on i2cm_pkg and i2cm_step.
//
//  channel   | dir | payload (low bit first)
//  s_axis    | in  | cmd_valid, mode[1:0], tx_byte[7:0], ack_to_send, sda_in
//  m_axis    | out | scl, sda_drive, busy_res, done_res, rx_byte[7:0], ack_seen
//  apb       | in  | half_period at byte address 0
//
// One tick per cycle while m_axis does not stall: each accepted transfer updates the
// state and loads the result register in the same cycle.
// Stalls on m_axis hold s_axis_tready low until the waiting result is taken.
// rst is synchronous: idle, SCL and SDA released, half_period back to 5.
module i2c_master_byte_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] cmd_valid, [2:1] mode, [10:3] tx_byte, [11] ack_to_send, [12] sda_in
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl, [1] sda_drive, [2] busy_res, [3] done_res, [11:4] rx_byte, [12] ack_seen
  output logic [15:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cm_pkg::state_t st;
  i2cm_pkg::state_t st_next;
  i2cm_pkg::cmd_t   cmd;
  i2cm_pkg::res_t   res;
  logic [7:0]       half_period;
  logic             in_fire;
  logic             reg_sel;

  assign cmd           = s_axis_tdata[12:0];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign pready        = 1'b1;
  assign reg_sel       = (paddr[2] == i2cm_pkg::REG_HALF_PERIOD);
  assign prdata        = reg_sel ? {24'd0, half_period} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cm_pkg::HALF_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      half_period <= pwdata[7:0];
    end
  end

  i2cm_step u_step (
    .st          (st),
    .cmd         (cmd),
    .half_period (half_period),
    .st_next     (st_next),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.active     <= 1'b0;
      st.mode       <= i2cm_pkg::MODE_START;
      st.phase      <= 5'd0;
      st.wait_count <= 8'd0;
      st.shift_reg  <= 8'd0;
      st.scl_level  <= 1'b1;
      st.sda_level  <= 1'b1;
      st.ack_reg    <= 1'b0;
      st.rx_hold    <= 8'd0;
      st.ack_out    <= 1'b0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= {3'd0, res};
    end
  end

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
    else $error("done without busy");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result waits");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    st.active |-> st.phase < i2cm_pkg::SEG_LONG)
    else $error("phase out of range");

  a_wait_bound: assert property (@(posedge clk) disable iff (rst)
    st.active && half_period != 8'd0 |-> st.wait_count < half_period)
    else $error("wait count past half period");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire && res.done_res |=> !st.active)
    else $error("still active after done");
`endif

endmodule

// ----- dv/tb_i2c_master_byte_engine_top.sv -----
// Self-checking testbench for i2c_master_byte_engine_top: one stream transfer per
// bit-timer tick, each result checked against a tick-level line predictor or, for typed rows, a fixed value.
// Depends on i2cm_pkg and the RTL under src/.
module tb_i2c_master_byte_engine_top;

  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [7:0] MSB_MASK    = 8'h80;
  localparam logic [2:0] HP_ADDR     = 3'(4 * i2cm_pkg::REG_HALF_PERIOD);

  localparam i2cm_pkg::res_t RES_IDLE  = '{ack_seen: 1'b0, rx_byte: 8'h00, done_res: 1'b0,
                                           busy_res: 1'b0, sda_drive: 1'b1, scl: 1'b1};
  localparam i2cm_pkg::res_t RES_START = '{ack_seen: 1'b0, rx_byte: 8'h00, done_res: 1'b0,
                                           busy_res: 1'b1, sda_drive: 1'b1, scl: 1'b0};

  typedef struct packed {
    logic            go;
    i2cm_pkg::mode_t mode;
    logic [7:0]      tx;
    logic            ack_tx;
    logic [7:0]      sda_pat;   // bits returned by the slave, MSB first
    logic            sda_ack;   // slave level during the ack segments
    logic            poke;      // raise cmd_valid while busy
    logic            typed;
    i2cm_pkg::res_t  want;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [13] = '{
    '{1'b0, i2cm_pkg::MODE_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, RES_IDLE},
    '{1'b1, i2cm_pkg::MODE_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, RES_START},
    '{1'b1, i2cm_pkg::MODE_WRITE, 8'hff, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, RES_IDLE},
    '{1'b1, i2cm_pkg::MODE_WRITE, 8'h00, 1'b1, 8'hff, 1'b1, 1'b0, 1'b0, RES_IDLE},
    '{1'b1, i2cm_pkg::MODE_WRITE, 8'ha5, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, RES_IDLE},
    '{1'b1, i2cm_pkg::MODE_READ,  8'h00, 1'b0, 8'hff, 1'b1, 1'b0, 1'b0, RES_IDLE},
    '{1'b1, i2cm_pkg::MODE_READ,  8'hff, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, RES_IDLE},
    '{1'b1, i2cm_pkg::MODE_READ,  8'h00, 1'b1, 8'h5a, 1'b1, 1'b1, 1'b0, RES_IDLE},
    '{1'b1, i2cm_pkg::MODE_STOP,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, RES_IDLE},
    '{1'b1, i2cm_pkg::MODE_START, 8'h00, 1'b1, 8'hff, 1'b1, 1'b1, 1'b0, RES_IDLE},
    '{1'b1, i2cm_pkg::MODE_WRITE, 8'h3c, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, RES_IDLE},
    '{1'b1, i2cm_pkg::MODE_READ,  8'h00, 1'b0, 8'h81, 1'b0, 1'b0, 1'b0, RES_IDLE},
    '{1'b1, i2cm_pkg::MODE_STOP,  8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, RES_IDLE}
  };

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_byte_engine_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // line predictor state
  logic [7:0]      half_period = i2cm_pkg::HALF_PERIOD_RESET;
  logic            cmd_active  = 1'b0;
  i2cm_pkg::mode_t cmd_mode    = i2cm_pkg::MODE_START;
  logic [4:0]      seg         = '0;
  logic [7:0]      seg_ticks   = '0;
  logic [7:0]      shifter     = '0;
  logic            scl_lv      = 1'b1;
  logic            sda_lv      = 1'b1;
  logic            slave_ack   = 1'b0;
  logic [7:0]      rx_hold     = '0;
  logic            ack_tx      = 1'b0;

  i2cm_pkg::res_t tick_results_q[$];
  int             mismatches = 0;
  int             idle_pct   = 0;
  int             stall_pct  = 0;
  int             cycles     = 0;
  i2cm_pkg::res_t got_res;
  i2cm_pkg::res_t want_res;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = i2cm_pkg::res_t'(m_axis_tdata[12:0]);
        if (tick_results_q.size() == 0) begin
          $error("result transfer with none pending: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want_res = tick_results_q.pop_front();
          check_field("scl", want_res.scl, got_res.scl);
          check_field("sda_drive", want_res.sda_drive, got_res.sda_drive);
          check_field("busy_res", want_res.busy_res, got_res.busy_res);
          check_field("done_res", want_res.done_res, got_res.done_res);
          check_field("rx_byte", want_res.rx_byte, got_res.rx_byte);
          check_field("ack_seen", want_res.ack_seen, got_res.ack_seen);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic predict_tick(input i2cm_pkg::cmd_t c, output i2cm_pkg::res_t r);
    logic [7:0] hp;
    hp = (half_period == 8'd0) ? 8'd1 : half_period;
    r = '0;
    if (!cmd_active && c.cmd_valid) begin
      cmd_active = 1'b1;
      cmd_mode   = i2cm_pkg::mode_t'(c.mode);
      shifter    = (cmd_mode == i2cm_pkg::MODE_WRITE) ? c.tx_byte : 8'd0;
      ack_tx     = c.ack_to_send;
      seg        = '0;
      seg_ticks  = '0;
    end
    if (cmd_active) begin
      r.busy_res = 1'b1;
      if (seg_ticks == 8'd0) begin
        case (cmd_mode)
          i2cm_pkg::MODE_START: begin
            if (seg == 5'd0) begin
              scl_lv = 1'b0;
            end else if (seg == 5'd1) begin
              scl_lv = 1'b1;
              sda_lv = 1'b1;
            end else begin
              sda_lv = 1'b0;
            end
          end
          i2cm_pkg::MODE_STOP: begin
            if (seg == 5'd0) begin
              scl_lv = 1'b0;
            end else if (seg == 5'd1) begin
              sda_lv = 1'b0;
              scl_lv = 1'b1;
            end else begin
              sda_lv = 1'b1;
            end
          end
          default: begin
            if (seg < i2cm_pkg::PH_BITS_END) begin
              if (!seg[0]) begin
                scl_lv = 1'b0;
                sda_lv = (cmd_mode == i2cm_pkg::MODE_WRITE) ?
                         |(shifter & (MSB_MASK >> seg[3:1])) : 1'b1;
              end else begin
                scl_lv = 1'b1;
              end
            end else if (seg == i2cm_pkg::PH_ACK_LOW) begin
              scl_lv = 1'b0;
              sda_lv = (cmd_mode == i2cm_pkg::MODE_WRITE) ? 1'b1 : ack_tx;
            end else if (seg == i2cm_pkg::PH_ACK_HIGH) begin
              scl_lv = 1'b1;
            end else begin
              scl_lv = 1'b0;
            end
          end
        endcase
      end
      // read bits sampled on SCL rise, write ack at the end of its high phase
      if (cmd_mode == i2cm_pkg::MODE_READ && seg < i2cm_pkg::PH_BITS_END && seg[0] &&
          seg_ticks == 8'd0)
        shifter = {shifter[6:0], c.sda_in};
      if (cmd_mode == i2cm_pkg::MODE_WRITE && seg == i2cm_pkg::PH_ACK_HIGH &&
          seg_ticks == hp - 8'd1)
        slave_ack = c.sda_in;
      seg_ticks++;
      if (seg_ticks >= hp) begin
        seg_ticks = '0;
        seg++;
        if (seg >= ((cmd_mode == i2cm_pkg::MODE_START || cmd_mode == i2cm_pkg::MODE_STOP) ?
                    i2cm_pkg::SEG_SHORT : i2cm_pkg::SEG_LONG))
        begin
          r.done_res = 1'b1;
          if (cmd_mode == i2cm_pkg::MODE_READ)
            rx_hold = shifter;
          cmd_active = 1'b0;
          seg        = '0;
        end
      end
    end
    r.scl       = scl_lv;
    r.sda_drive = sda_lv;
    r.rx_byte   = rx_hold;
    r.ack_seen  = slave_ack;
  endtask

  task automatic send_tick(input i2cm_pkg::cmd_t c, input logic typed,
                           input i2cm_pkg::res_t want);
    i2cm_pkg::res_t r;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 16'($urandom);
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, c};
    do @(posedge clk); while (!s_axis_tready);
    predict_tick(c, r);
    tick_results_q.push_back(typed ? want : r);
  endtask

  function automatic i2cm_pkg::cmd_t rand_cmd();
    i2cm_pkg::cmd_t c;
    c = 13'($urandom);
    return c;
  endfunction

  function automatic logic slave_sda(input logic [7:0] pat, input logic ack);
    if (cmd_active && seg < i2cm_pkg::PH_BITS_END)
      return pat[3'd7 - seg[3:1]];
    return cmd_active ? ack : pat[7];
  endfunction

  task automatic apb_write(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HP_ADDR;
    pwdata  <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    half_period = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= HP_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, v}) begin
      $error("half_period: expected %0d, got %0d", v, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // finish any command in flight, then wait for every result
  task automatic settle();
    i2cm_pkg::cmd_t c;
    while (cmd_active) begin
      c = rand_cmd();
      c.cmd_valid = 1'b0;
      send_tick(c, 1'b0, RES_IDLE);
    end
    s_axis_tvalid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] hp, input int idle, input int stall, input int n);
    i2cm_pkg::cmd_t c;
    apb_write(hp);
    apb_read_check(hp);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      c = rand_cmd();
      c.cmd_valid = cmd_active ? ($urandom_range(99) < 25) : ($urandom_range(99) < 75);
      send_tick(c, 1'b0, RES_IDLE);
    end
    settle();
  endtask

  initial begin
    dir_row_t       row;
    i2cm_pkg::cmd_t c;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_read_check(i2cm_pkg::HALF_PERIOD_RESET);
    apb_write(8'd2);
    apb_read_check(8'd2);

    foreach (DIR_TABLE[i]) begin
      row = DIR_TABLE[i];
      c.cmd_valid   = row.go;
      c.mode        = row.mode;
      c.tx_byte     = row.tx;
      c.ack_to_send = row.ack_tx;
      c.sda_in      = slave_sda(row.sda_pat, row.sda_ack);
      send_tick(c, row.typed, row.want);
      while (cmd_active) begin
        c = rand_cmd();
        c.cmd_valid = row.poke;
        c.sda_in    = slave_sda(row.sda_pat, row.sda_ack);
        send_tick(c, 1'b0, RES_IDLE);
      end
    end
    settle();

    apb_write(8'd255);
    apb_read_check(8'd255);

    run_phase(8'd1,   0,  0,  120);
    run_phase(8'd0,   67, 0,  100);
    run_phase(8'd2,   0,  67, 100);
    run_phase(8'd3,   7,  7,  100);
    run_phase(8'd1,   0,  67, 60);
    run_phase(8'($urandom_range(9, 4)), 67, 0, 60);
    run_phase(8'd2,   0,  0,  60);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
